// ===== rtl/mmtp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MMTP header parser package
// Shared constants for the byte-serial MMTP packet header parser: result
// kinds, fixed header length and a byte-placement helper.
// ----------------------------------------------------------------------------
package mmtp_pkg;

  localparam int unsigned HEADER_LEN = 12;
  localparam int unsigned POS_W      = 4;

  localparam logic [5:0] PKT_TYPE_MASK = 6'h3F;

  // Result kinds.
  localparam logic [2:0] KIND_HDR   = 3'd0;
  localparam logic [2:0] KIND_DONE  = 3'd1;
  localparam logic [2:0] KIND_EXT   = 3'd2;
  localparam logic [2:0] KIND_PAY   = 3'd3;
  localparam logic [2:0] KIND_LAST  = 3'd4;
  localparam logic [2:0] KIND_SHORT = 3'd5;
  localparam logic [2:0] KIND_NOPAY = 3'd6;

  // Merge one byte into a big-endian 32-bit word; slot 0 is the top byte.
  function automatic logic [31:0] place_byte(input logic [31:0] word,
                                             input logic [1:0]  slot,
                                             input logic [7:0]  data);
    logic [31:0] merged;
    merged = word;
    case (slot)
      2'd0:    merged[31:24] = word[31:24] | data;
      2'd1:    merged[23:16] = word[23:16] | data;
      2'd2:    merged[15:8]  = word[15:8]  | data;
      default: merged[7:0]   = word[7:0]   | data;
    endcase
    return merged;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mmtp_header_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MMTP packet header parser
// Byte-serial parser that unpacks the MMTP fixed header, the optional packet
// counter and the optional extension header, and passes extension and
// payload bytes through with one result item per input byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one packet byte per item, with
//   end_of_packet set on the final byte of each packet. Output channel
//   (out_valid/out_ready) returns exactly one result item per input item:
//   a kind code, all header fields received so far and the passed byte.
//   The result is registered: the result of an item accepted at one edge is
//   valid after that edge. Throughput is one item per cycle while the
//   receiver keeps out_ready high; the only storage between the channels is
//   the result register, so in_ready follows out_ready whenever a result is
//   pending. If the receiver stalls, the result register holds its item and
//   in_ready drops until it is taken; no item is lost or repeated.
//   Reset clears the parse state to the start of a packet and empties the
//   result register; the result fields carry no meaning until out_valid rises.
//   After any byte flagged end_of_packet the next byte starts a new packet.
// ----------------------------------------------------------------------------
module mmtp_header_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        end_of_packet,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       kind,
  output logic [1:0]       version,
  output logic [1:0]       fec_code,
  output logic [2:0]       flag_bits,
  output logic [5:0]       pkt_type,
  output logic [15:0]      pkt_id,
  output logic [31:0]      timestamp,
  output logic [31:0]      sequence_number,
  output logic [31:0]      packet_count,
  output logic [15:0]      extension_type,
  output logic [15:0]      ext_length,
  output logic [7:0]       out_byte
);

  typedef enum logic [2:0] {
    PH_FIXED,
    PH_COUNTER,
    PH_EXTHDR,
    PH_EXTBYTES,
    PH_PAYLOAD
  } phase_t;

  phase_t                         phase, phase_next;
  logic [mmtp_pkg::POS_W-1:0]     byte_position, byte_position_next;
  logic [15:0]                    extension_remaining, extension_remaining_next;
  logic [31:0]                    hdr0, hdr0_next;
  logic [31:0]                    hdr1, hdr1_next;
  logic [31:0]                    hdr2, hdr2_next;
  logic [31:0]                    cnt_word, cnt_word_next;
  logic [31:0]                    ext_word, ext_word_next;
  logic [2:0]                     kind_next;
  logic [7:0]                     out_byte_next;

  logic                           in_fire;
  logic [mmtp_pkg::POS_W-1:0]     pos;
  logic                           go_counter, go_exthdr, complete;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    phase_next               = phase;
    byte_position_next       = byte_position;
    extension_remaining_next = extension_remaining;
    hdr0_next                = hdr0;
    hdr1_next                = hdr1;
    hdr2_next                = hdr2;
    cnt_word_next            = cnt_word;
    ext_word_next            = ext_word;
    kind_next                = mmtp_pkg::KIND_HDR;
    out_byte_next            = 8'd0;
    go_counter               = 1'b0;
    go_exthdr                = 1'b0;
    complete                 = 1'b0;
    pos                      = byte_position;

    case (phase)
      PH_COUNTER, PH_EXTHDR: begin
        pos = {2'b00, byte_position[1:0]};
        if (phase == PH_COUNTER) begin
          cnt_word_next = mmtp_pkg::place_byte(cnt_word, pos[1:0], in_byte);
        end else begin
          ext_word_next = mmtp_pkg::place_byte(ext_word, pos[1:0], in_byte);
        end
        if (pos[1:0] == 2'd3) begin
          if (phase == PH_COUNTER && hdr0[25]) begin
            go_exthdr = 1'b1;
          end else begin
            complete = 1'b1;
          end
        end else if (end_of_packet) begin
          kind_next          = mmtp_pkg::KIND_SHORT;
          phase_next         = PH_FIXED;
          byte_position_next = '0;
        end else begin
          byte_position_next = pos + mmtp_pkg::POS_W'(1);
        end
      end
      PH_EXTBYTES: begin
        out_byte_next = in_byte;
        if (extension_remaining != 16'd0) begin
          extension_remaining_next = extension_remaining - 16'd1;
        end
        kind_next = mmtp_pkg::KIND_EXT;
        if (end_of_packet) begin
          kind_next = (extension_remaining_next != 16'd0) ? mmtp_pkg::KIND_SHORT
                                                          : mmtp_pkg::KIND_NOPAY;
          phase_next         = PH_FIXED;
          byte_position_next = '0;
        end else if (extension_remaining_next == 16'd0) begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        out_byte_next = in_byte;
        if (end_of_packet) begin
          kind_next          = mmtp_pkg::KIND_LAST;
          phase_next         = PH_FIXED;
          byte_position_next = '0;
        end else begin
          kind_next = mmtp_pkg::KIND_PAY;
        end
      end
      default: begin
        // Fixed header; unused phase codes restart here at position zero.
        if (phase != PH_FIXED ||
            byte_position >= mmtp_pkg::POS_W'(mmtp_pkg::HEADER_LEN)) begin
          pos = '0;
        end
        if (pos == '0) begin
          hdr0_next                = 32'd0;
          hdr1_next                = 32'd0;
          hdr2_next                = 32'd0;
          cnt_word_next            = 32'd0;
          ext_word_next            = 32'd0;
          extension_remaining_next = 16'd0;
        end
        case (pos[3:2])
          2'd0:    hdr0_next = mmtp_pkg::place_byte(hdr0_next, pos[1:0], in_byte);
          2'd1:    hdr1_next = mmtp_pkg::place_byte(hdr1_next, pos[1:0], in_byte);
          default: hdr2_next = mmtp_pkg::place_byte(hdr2_next, pos[1:0], in_byte);
        endcase
        if (pos == mmtp_pkg::POS_W'(mmtp_pkg::HEADER_LEN - 1)) begin
          if (hdr0_next[29]) begin
            go_counter = 1'b1;
          end else if (hdr0_next[25]) begin
            go_exthdr = 1'b1;
          end else begin
            complete = 1'b1;
          end
        end else if (end_of_packet) begin
          kind_next          = mmtp_pkg::KIND_SHORT;
          phase_next         = PH_FIXED;
          byte_position_next = '0;
        end else begin
          phase_next         = PH_FIXED;
          byte_position_next = pos + mmtp_pkg::POS_W'(1);
        end
      end
    endcase

    // Transition out of a finished header part.
    if (complete) begin
      extension_remaining_next = hdr0_next[25] ? ext_word_next[15:0] : 16'd0;
      byte_position_next       = '0;
      if (end_of_packet) begin
        kind_next  = (extension_remaining_next != 16'd0) ? mmtp_pkg::KIND_SHORT
                                                         : mmtp_pkg::KIND_NOPAY;
        phase_next = PH_FIXED;
      end else begin
        kind_next  = mmtp_pkg::KIND_DONE;
        phase_next = (extension_remaining_next != 16'd0) ? PH_EXTBYTES : PH_PAYLOAD;
      end
    end else if (go_counter || go_exthdr) begin
      byte_position_next = '0;
      if (end_of_packet) begin
        kind_next  = mmtp_pkg::KIND_SHORT;
        phase_next = PH_FIXED;
      end else begin
        kind_next  = mmtp_pkg::KIND_HDR;
        phase_next = go_counter ? PH_COUNTER : PH_EXTHDR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_FIXED;
      byte_position       <= '0;
      extension_remaining <= 16'd0;
      hdr0                <= 32'd0;
      hdr1                <= 32'd0;
      hdr2                <= 32'd0;
      cnt_word            <= 32'd0;
      ext_word            <= 32'd0;
      out_valid           <= 1'b0;
    end else begin
      if (in_fire) begin
        phase               <= phase_next;
        byte_position       <= byte_position_next;
        extension_remaining <= extension_remaining_next;
        hdr0                <= hdr0_next;
        hdr1                <= hdr1_next;
        hdr2                <= hdr2_next;
        cnt_word            <= cnt_word_next;
        ext_word            <= ext_word_next;
        out_valid           <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload registers; loaded with each accepted item.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind            <= kind_next;
      version         <= hdr0_next[31:30];
      fec_code        <= hdr0_next[28:27];
      flag_bits       <= {hdr0_next[29], hdr0_next[25], hdr0_next[24]};
      pkt_type        <= hdr0_next[21:16] & mmtp_pkg::PKT_TYPE_MASK;
      pkt_id          <= hdr0_next[15:0];
      timestamp       <= hdr1_next;
      sequence_number <= hdr2_next;
      packet_count    <= cnt_word_next;
      extension_type  <= ext_word_next[31:16];
      ext_length      <= ext_word_next[15:0];
      out_byte        <= out_byte_next;
    end
  end

`ifndef ASSERT_OFF
  a_pos_in_header: assert property (@(posedge clk) disable iff (rst)
    byte_position < mmtp_pkg::POS_W'(mmtp_pkg::HEADER_LEN))
    else $error("byte position ran past the fixed header");

  a_ext_pending: assert property (@(posedge clk) disable iff (rst)
    phase == PH_EXTBYTES |-> extension_remaining != 16'd0)
    else $error("extension phase entered with nothing left to pass");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    in_fire && end_of_packet |=> phase == PH_FIXED && byte_position == '0)
    else $error("parser did not restart after the final byte of a packet");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted item produced no result");

  a_header_no_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == mmtp_pkg::KIND_HDR || kind == mmtp_pkg::KIND_DONE)
      |-> out_byte == 8'd0)
    else $error("header result carries a passed byte");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/mmtp_header_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MMTP header parser testbench
// Feeds byte streams of MMTP packets into the parser and checks every result
// item against a cycle-free parser model kept in the bench. Packets are
// mostly well formed with random header content, counters and extensions,
// mixed with truncated packets and random noise. The sender runs in bursts
// with random gaps and the receiver stalls on a changing ready pattern.
// ----------------------------------------------------------------------------
module mmtp_header_parser_tb;

  localparam int unsigned ITEM_TARGET = 750;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 4;

  typedef enum logic [2:0] {
    PH_FIXED,
    PH_COUNTER,
    PH_EXTHDR,
    PH_EXTBYTES,
    PH_PAYLOAD
  } parse_phase_t;

  typedef enum int {
    PKT_GOOD,
    PKT_CUT,
    PKT_NOISE
  } packet_shape_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  version;
    logic [1:0]  fec_code;
    logic [2:0]  flag_bits;
    logic [5:0]  pkt_type;
    logic [15:0] pkt_id;
    logic [31:0] timestamp;
    logic [31:0] sequence_number;
    logic [31:0] packet_count;
    logic [15:0] extension_type;
    logic [15:0] ext_length;
    logic [7:0]  out_byte;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        end_of_packet = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [1:0]  version;
  logic [1:0]  fec_code;
  logic [2:0]  flag_bits;
  logic [5:0]  pkt_type;
  logic [15:0] pkt_id;
  logic [31:0] timestamp;
  logic [31:0] sequence_number;
  logic [31:0] packet_count;
  logic [15:0] extension_type;
  logic [15:0] ext_length;
  logic [7:0]  out_byte;

  mmtp_header_parser i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .end_of_packet   (end_of_packet),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .version         (version),
    .fec_code        (fec_code),
    .flag_bits       (flag_bits),
    .pkt_type        (pkt_type),
    .pkt_id          (pkt_id),
    .timestamp       (timestamp),
    .sequence_number (sequence_number),
    .packet_count    (packet_count),
    .extension_type  (extension_type),
    .ext_length      (ext_length),
    .out_byte        (out_byte)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stream_byte_t  byte_stream[$];
  parse_result_t expected_results[$];

  // Parser model state.
  parse_phase_t parse_phase = PH_FIXED;
  int unsigned  parse_pos = 0;
  logic [15:0]  ext_left = '0;
  logic [31:0]  hdr_word[0:2] = '{default: '0};
  logic [31:0]  counter_word = '0;
  logic [31:0]  ext_word = '0;

  int unsigned cycle_count = 0;
  int unsigned bytes_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned packets_queued = 0;
  int unsigned mismatches = 0;
  int unsigned kind_seen[0:7] = '{default: 0};
  bit          in_fire = 1'b0;

  function automatic logic [31:0] merge_byte(logic [31:0] word, int unsigned pos,
                                             logic [7:0] b);
    return word | ({24'h0, b} << (8 * (3 - (pos & 3))));
  endfunction

  function automatic logic [2:0] close_header(logic eop);
    ext_left = hdr_word[0][25] ? ext_word[15:0] : 16'd0;
    parse_pos = 0;
    if (eop) begin
      parse_phase = PH_FIXED;
      return (ext_left != 0) ? mmtp_pkg::KIND_SHORT : mmtp_pkg::KIND_NOPAY;
    end
    parse_phase = (ext_left != 0) ? PH_EXTBYTES : PH_PAYLOAD;
    return mmtp_pkg::KIND_DONE;
  endfunction

  // Picks the next header part once the fixed header or the counter is in.
  function automatic logic [2:0] next_part(logic eop, bit from_fixed);
    parse_phase_t nxt;
    if (from_fixed && hdr_word[0][29]) begin
      nxt = PH_COUNTER;
    end else if (hdr_word[0][25]) begin
      nxt = PH_EXTHDR;
    end else begin
      return close_header(eop);
    end
    parse_pos = 0;
    if (eop) begin
      parse_phase = PH_FIXED;
      return mmtp_pkg::KIND_SHORT;
    end
    parse_phase = nxt;
    return mmtp_pkg::KIND_HDR;
  endfunction

  function automatic parse_result_t parse_byte(logic [7:0] b, logic eop);
    parse_result_t r;
    logic [2:0]    k;
    logic [7:0]    passed;
    k = mmtp_pkg::KIND_HDR;
    passed = 8'h00;
    case (parse_phase)
      PH_FIXED: begin
        if (parse_pos == 0) begin
          hdr_word = '{default: '0};
          counter_word = '0;
          ext_word = '0;
          ext_left = '0;
        end
        hdr_word[parse_pos >> 2] = merge_byte(hdr_word[parse_pos >> 2], parse_pos, b);
        if (parse_pos == mmtp_pkg::HEADER_LEN - 1) begin
          k = next_part(eop, 1'b1);
        end else if (eop) begin
          k = mmtp_pkg::KIND_SHORT;
          parse_pos = 0;
        end else begin
          parse_pos++;
        end
      end
      PH_COUNTER, PH_EXTHDR: begin
        parse_pos &= 3;
        if (parse_phase == PH_COUNTER) begin
          counter_word = merge_byte(counter_word, parse_pos, b);
        end else begin
          ext_word = merge_byte(ext_word, parse_pos, b);
        end
        if (parse_pos == 3) begin
          k = (parse_phase == PH_COUNTER) ? next_part(eop, 1'b0) : close_header(eop);
        end else if (eop) begin
          k = mmtp_pkg::KIND_SHORT;
          parse_phase = PH_FIXED;
          parse_pos = 0;
        end else begin
          parse_pos++;
        end
      end
      PH_EXTBYTES: begin
        passed = b;
        if (ext_left != 0) ext_left--;
        k = mmtp_pkg::KIND_EXT;
        if (eop) begin
          k = (ext_left != 0) ? mmtp_pkg::KIND_SHORT : mmtp_pkg::KIND_NOPAY;
          parse_phase = PH_FIXED;
          parse_pos = 0;
        end else if (ext_left == 0) begin
          parse_phase = PH_PAYLOAD;
        end
      end
      default: begin
        passed = b;
        if (eop) begin
          k = mmtp_pkg::KIND_LAST;
          parse_phase = PH_FIXED;
          parse_pos = 0;
        end else begin
          k = mmtp_pkg::KIND_PAY;
        end
      end
    endcase
    r.kind            = k;
    r.version         = hdr_word[0][31:30];
    r.fec_code        = hdr_word[0][28:27];
    r.flag_bits       = {hdr_word[0][29], hdr_word[0][25], hdr_word[0][24]};
    r.pkt_type        = hdr_word[0][21:16] & mmtp_pkg::PKT_TYPE_MASK;
    r.pkt_id          = hdr_word[0][15:0];
    r.timestamp       = hdr_word[1];
    r.sequence_number = hdr_word[2];
    r.packet_count    = counter_word;
    r.extension_type  = ext_word[31:16];
    r.ext_length      = ext_word[15:0];
    r.out_byte        = passed;
    return r;
  endfunction

  function automatic string describe(parse_result_t r);
    return $sformatf({"kind=%0d ver=%0d fec=%0d flags=%b ptype=%h pid=%h ts=%h seq=%h ",
                      "cnt=%h etype=%h elen=%h byte=%h"},
                     r.kind, r.version, r.fec_code, r.flag_bits, r.pkt_type,
                     r.pkt_id, r.timestamp, r.sequence_number, r.packet_count,
                     r.extension_type, r.ext_length, r.out_byte);
  endfunction

  task automatic push_bytes(logic [7:0] bytes[$], int unsigned count);
    stream_byte_t item;
    for (int unsigned i = 0; i < count; i++) begin
      item.data = bytes[i];
      item.last = (i == count - 1);
      byte_stream.push_back(item);
    end
    packets_queued++;
  endtask

  // Builds one packet: a well-formed one, one cut short anywhere, or noise.
  task automatic queue_random_packet();
    logic [7:0]    bytes[$];
    logic [7:0]    first;
    logic [15:0]   ext_len;
    bit            has_counter;
    bit            has_ext;
    bit            oversize;
    int unsigned   pick;
    int unsigned   count;
    packet_shape_t shape;
    pick = $urandom_range(0, 99);
    shape = (pick < 75) ? PKT_GOOD : (pick < 95) ? PKT_CUT : PKT_NOISE;
    oversize = 1'b0;
    has_counter = 1'($urandom_range(0, 1));
    has_ext = 1'($urandom_range(0, 1));
    first = 8'($urandom);
    first[5] = has_counter;
    first[1] = has_ext;
    bytes.push_back(first);
    repeat (mmtp_pkg::HEADER_LEN - 1) bytes.push_back(8'($urandom));
    if (has_counter) repeat (4) bytes.push_back(8'($urandom));
    if (has_ext) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) ext_len = 16'($urandom_range(0, 6));
      else if (pick == 7) ext_len = 16'd0;
      else if (pick == 8) ext_len = 16'($urandom);
      else ext_len = 16'hFFFF;
      bytes.push_back(8'($urandom));
      bytes.push_back(8'($urandom));
      bytes.push_back(ext_len[15:8]);
      bytes.push_back(ext_len[7:0]);
      // Long extensions get 24 random bytes and the packet is cut at a random byte.
      if (ext_len > 16) begin
        oversize = 1'b1;
        repeat (24) bytes.push_back(8'($urandom));
      end else begin
        repeat (ext_len) bytes.push_back(8'($urandom));
      end
    end
    if (!oversize && $urandom_range(0, 3) != 0) begin
      repeat ($urandom_range(1, 12)) bytes.push_back(8'($urandom));
    end
    if (shape == PKT_NOISE) begin
      bytes.delete();
      repeat ($urandom_range(1, 16)) bytes.push_back(8'($urandom));
    end
    count = bytes.size();
    if (shape == PKT_CUT || oversize) count = $urandom_range(1, bytes.size());
    push_bytes(bytes, count);
  endtask

  task automatic check_result();
    parse_result_t got;
    parse_result_t want;
    got = {kind, version, fec_code, flag_bits, pkt_type, pkt_id, timestamp,
           sequence_number, packet_count, extension_type, ext_length, out_byte};
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: result with none expected: %s", describe(got));
      return;
    end
    want = expected_results.pop_front();
    results_checked++;
    kind_seen[want.kind]++;
    if (got != want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: result %0d mismatch", results_checked);
        $display("  expected %s", describe(want));
        $display("  actual   %s", describe(got));
      end
    end
  endtask

  // Output check comes first: a result at this edge belongs to an older item.
  always @(posedge clk) begin
    cycle_count++;
    in_fire = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) begin
        in_fire = 1'b1;
        bytes_accepted++;
        expected_results.push_back(parse_byte(in_byte, end_of_packet));
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles", cycle_count);
      $display("mmtp_header_parser_tb failed");
      $finish;
    end
  end

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  stream_byte_t next_item;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // Hold the current item until it is taken.
    end else if (gap_left != 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (byte_stream.size() != 0) begin
      next_item = byte_stream.pop_front();
      in_valid <= 1'b1;
      in_byte <= next_item.data;
      end_of_packet <= next_item.last;
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: a rotating ready pattern that is replaced now and then.
  logic [15:0] ready_pattern = 16'hFFFF;
  int unsigned pattern_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        case ($urandom_range(0, 3))
          0:       ready_pattern = 16'hFFFF;
          1:       ready_pattern = 16'($urandom);
          2:       ready_pattern = 16'($urandom & $urandom);
          default: ready_pattern = 16'($urandom | $urandom);
        endcase
        pattern_left = $urandom_range(16, 200);
      end
      pattern_left--;
      out_ready <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end
  end

  initial begin
    logic [7:0] bytes[$];
    // A one-byte packet, a header whose flags announce a counter that never
    // comes, and a bare header with no payload.
    bytes = '{8'hFF};
    push_bytes(bytes, 1);
    bytes.delete();
    repeat (mmtp_pkg::HEADER_LEN) bytes.push_back(8'hFF);
    push_bytes(bytes, mmtp_pkg::HEADER_LEN);
    bytes.delete();
    repeat (mmtp_pkg::HEADER_LEN) bytes.push_back(8'h00);
    push_bytes(bytes, mmtp_pkg::HEADER_LEN);
    while (byte_stream.size() < ITEM_TARGET) queue_random_packet();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (byte_stream.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d packets as %0d bytes; %0d results checked in %0d cycles.",
             packets_queued, bytes_accepted, results_checked, cycle_count);
    $display("Kinds seen: hdr %0d done %0d ext %0d pay %0d last %0d short %0d nopay %0d",
             kind_seen[mmtp_pkg::KIND_HDR], kind_seen[mmtp_pkg::KIND_DONE],
             kind_seen[mmtp_pkg::KIND_EXT], kind_seen[mmtp_pkg::KIND_PAY],
             kind_seen[mmtp_pkg::KIND_LAST], kind_seen[mmtp_pkg::KIND_SHORT],
             kind_seen[mmtp_pkg::KIND_NOPAY]);
    if (mismatches == 0) begin
      $display("mmtp_header_parser_tb passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("mmtp_header_parser_tb failed");
    end
    $finish;
  end

endmodule
